@@ rtl/tsc_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tsc_pkg
// shared types and constants for the topological sort with cycle check
// ----------------------------------------------------------------------------
package tsc_pkg;

    localparam int MAX_NODES_DEF = 32;
    localparam int ROW_W         = 32;
    localparam int IDX_W         = 5;
    localparam int CNT_W         = 6;
    localparam int STATUS_W      = 2;

    localparam logic [CNT_W-1:0] NODE_COUNT_RST = 6'd32;

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_START = 1'b1;

    localparam logic [STATUS_W-1:0] ST_EMIT    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_ACYCLIC = 2'd1;
    localparam logic [STATUS_W-1:0] ST_CYCLE   = 2'd2;

    typedef struct packed {
        logic             req_type;
        logic [IDX_W-1:0] row_index;
        logic [ROW_W-1:0] row_bits;
    } t_in_item;

    typedef struct packed {
        logic [IDX_W-1:0]    node_index;
        logic [STATUS_W-1:0] status;
        logic                last;
    } t_out_item;

    typedef struct packed {
        logic clr;
        logic inc;
        logic dec;
    } t_lane_ctl;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INIT,
        S_DRAIN,
        S_PICK,
        S_UPDATE,
        S_FINAL
    } t_state;

endpackage
`default_nettype wire

@@ rtl/tsc_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tsc_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module tsc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic             i_rd_en,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule
`default_nettype wire

@@ rtl/tsc_lane.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tsc_lane
// per-node in-degree counter: counts incoming edges, then takes them away
// ----------------------------------------------------------------------------
module tsc_lane (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire tsc_pkg::t_lane_ctl  i_ctl,
    input  wire logic                i_edge,
    output logic                     o_zero
);
    import tsc_pkg::*;

    logic [CNT_W-1:0] r_deg;
    logic [CNT_W-1:0] n_deg;

    always_comb begin
        n_deg = r_deg;
        if (i_ctl.clr) begin
            n_deg = '0;
        end else if (i_ctl.inc && i_edge) begin
            n_deg = r_deg + CNT_W'(1);
        end else if (i_ctl.dec && i_edge && (r_deg != '0)) begin
            n_deg = r_deg - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deg <= '0;
        end else begin
            r_deg <= n_deg;
        end
    end

    assign o_zero = (r_deg == '0);

endmodule
`default_nettype wire

@@ rtl/tsc_merge.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tsc_merge
// combines the lane flags: lowest-numbered ready node wins
// ----------------------------------------------------------------------------
module tsc_merge #(
    parameter int DEPTH = 32,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic [DEPTH-1:0] i_cand,
    output logic                  o_found,
    output logic [AW-1:0]         o_pick
);

    always_comb begin
        o_pick = '0;
        for (int j = DEPTH - 1; j >= 0; j--) begin
            if (i_cand[j]) begin
                o_pick = AW'(j);
            end
        end
    end

    assign o_found = |i_cand;

endmodule
`default_nettype wire

@@ rtl/topological_sort_cycle_check_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// topological_sort_cycle_check_top
// kahn topological sort over a stored adjacency matrix with cycle check
// ----------------------------------------------------------------------------
// channels: input transactions (load row or start sort), result transactions
// (emitted node, then one final acyclic or cycle status with last set), and a
// config write channel carrying node_count, always ready.
// a row load gives no result; loads may follow back to back. a start first
// sweeps the rows of the nodes in use through the row ram, one row per cycle,
// with every lane counting its in-degree. each node then passes through
// S_PICK, which picks it in the merge stage and issues the row read, and then
// S_UPDATE, in which the lanes take away its edges. the final status follows.
// new input is taken only when no run is in progress.
// results go through a single output register; when the receiver stalls, the
// sort pauses until the register is free.
// reset clears the row valid bits (the stored graph reads as empty), the
// in-degree lanes, and sets node_count to 32. no clearing pass is needed.
// ----------------------------------------------------------------------------
module topological_sort_cycle_check_top #(
    parameter int MAX_NODES = tsc_pkg::MAX_NODES_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_in_valid,
    output logic                                  o_in_ready,
    input  wire tsc_pkg::t_in_item                i_in_data,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_ready,
    output tsc_pkg::t_out_item                    o_out_data,
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [tsc_pkg::CNT_W-1:0]        i_cfg_data
);
    import tsc_pkg::*;

    localparam int DEPTH = (MAX_NODES < ROW_W) ? MAX_NODES : ROW_W;
    localparam int AW    = $clog2(DEPTH);

    t_state           r_state;
    t_state           n_state;
    logic [CNT_W-1:0] r_node_count;
    logic [CNT_W-1:0] eff_n;
    logic [CNT_W-1:0] r_emitted;
    logic [AW-1:0]    r_cnt;
    logic [DEPTH-1:0] r_visited;
    logic [DEPTH-1:0] r_row_vld;
    logic             r_rd_vld;
    logic             r_rd_init;
    logic             r_rd_upd;
    logic             r_out_valid;
    t_out_item        r_out_data;

    logic             in_fire;
    logic             load_wr;
    logic             start;
    logic             out_free;
    logic             rd_en;
    logic [AW-1:0]    rd_addr;
    logic             emit;
    logic             end_cycle;
    logic             end_acyc;
    logic [ROW_W-1:0] ram_q;
    logic [DEPTH-1:0] in_use;
    logic [DEPTH-1:0] zero;
    logic [DEPTH-1:0] cand;
    logic             found;
    logic [AW-1:0]    pick;
    t_lane_ctl        lane_ctl;

    // handshakes
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_fire     = i_in_valid && o_in_ready;
    assign load_wr     = in_fire && (i_in_data.req_type == REQ_LOAD)
                         && ({1'b0, i_in_data.row_index} < CNT_W'(DEPTH));
    assign start       = in_fire && (i_in_data.req_type == REQ_START);
    assign out_free    = !r_out_valid || i_out_ready;

    assign eff_n = (r_node_count > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : r_node_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= NODE_COUNT_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_node_count <= i_cfg_data;
        end
    end

    // adjacency rows
    tsc_ram #(
        .WIDTH (ROW_W),
        .DEPTH (DEPTH)
    ) u_rows (
        .i_clk     (i_clk),
        .i_wr_en   (load_wr),
        .i_wr_addr (i_in_data.row_index[AW-1:0]),
        .i_wr_data (i_in_data.row_bits),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (ram_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_vld <= '0;
            r_rd_vld  <= 1'b0;
            r_rd_init <= 1'b0;
            r_rd_upd  <= 1'b0;
        end else begin
            if (load_wr) begin
                r_row_vld[i_in_data.row_index[AW-1:0]] <= 1'b1;
            end
            if (rd_en) begin
                r_rd_vld <= r_row_vld[rd_addr];
            end
            r_rd_init <= (r_state == S_INIT);
            r_rd_upd  <= emit;
        end
    end

    // in-degree lanes
    assign lane_ctl.clr = start;
    assign lane_ctl.inc = r_rd_init;
    assign lane_ctl.dec = r_rd_upd;

    for (genvar j = 0; j < DEPTH; j++) begin : g_lane
        assign in_use[j] = (CNT_W'(j) < eff_n);
        tsc_lane u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (lane_ctl),
            .i_edge  (r_rd_vld && ram_q[j] && in_use[j]),
            .o_zero  (zero[j])
        );
    end

    assign cand = ~r_visited & zero & in_use;

    tsc_merge #(
        .DEPTH (DEPTH)
    ) u_merge (
        .i_cand  (cand),
        .o_found (found),
        .o_pick  (pick)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = (eff_n == '0) ? S_FINAL : S_INIT;
                end
            end
            S_INIT: begin
                if (CNT_W'(r_cnt) == (eff_n - CNT_W'(1))) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: n_state = S_PICK;
            S_PICK: begin
                if (out_free) begin
                    n_state = found ? S_UPDATE : S_IDLE;
                end
            end
            S_UPDATE: n_state = (r_emitted == eff_n) ? S_FINAL : S_PICK;
            S_FINAL: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        rd_en     = 1'b0;
        rd_addr   = r_cnt;
        emit      = 1'b0;
        end_cycle = 1'b0;
        end_acyc  = 1'b0;
        case (r_state)
            S_INIT: begin
                rd_en = 1'b1;
            end
            S_PICK: begin
                if (out_free && found) begin
                    rd_en   = 1'b1;
                    rd_addr = pick;
                    emit    = 1'b1;
                end else if (out_free) begin
                    end_cycle = 1'b1;
                end
            end
            S_FINAL: begin
                end_acyc = out_free;
            end
            default: begin
                rd_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_emitted   <= '0;
            r_visited   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (start) begin
                r_cnt     <= '0;
                r_emitted <= '0;
                r_visited <= '0;
            end else begin
                if (r_state == S_INIT) begin
                    r_cnt <= r_cnt + AW'(1);
                end
                if (emit) begin
                    r_emitted <= r_emitted + CNT_W'(1);
                    r_visited <= r_visited | (DEPTH'(1) << pick);
                end
            end
            if (emit || end_cycle || end_acyc) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_data.node_index <= IDX_W'(pick);
            r_out_data.status     <= ST_EMIT;
            r_out_data.last       <= 1'b0;
        end else if (end_cycle) begin
            r_out_data.node_index <= '0;
            r_out_data.status     <= ST_CYCLE;
            r_out_data.last       <= 1'b1;
        end else if (end_acyc) begin
            r_out_data.node_index <= '0;
            r_out_data.status     <= ST_ACYCLIC;
            r_out_data.last       <= 1'b1;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

`ifndef SYNTH
    a_pick_unvisited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |-> !r_visited[pick])
        else $error("picked node already visited");

    a_emit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (r_emitted <= eff_n))
        else $error("more nodes emitted than in use");

    a_update_after_pick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |=> (r_state == S_UPDATE) && lane_ctl.dec)
        else $error("emitted node not followed by lane update");

    a_visit_marked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |=> r_visited[$past(pick)])
        else $error("emitted node not marked visited");
`endif

endmodule
`default_nettype wire

@@ tb/tsc_checker.sv @@
// ----------------------------------------------------------------------------
// tsc_checker
// watches the input, result and config channels of the topological sort,
// keeps its own copy of the graph and node count, predicts every run in kahn
// order and compares each result transaction field by field
// ----------------------------------------------------------------------------
module tsc_checker
    import tsc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_ready,
    input  t_in_item   i_in_data,
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  t_out_item  i_out_data,
    input  logic       i_cfg_valid,
    input  logic       i_cfg_ready,
    input  logic [CNT_W-1:0] i_cfg_data,
    output int         o_errors,
    output int         o_pending,
    output int         o_results
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NODES = MAX_NODES_DEF;

    logic [ROW_W-1:0] adjacency [NODES];
    logic [CNT_W-1:0] in_deg [NODES];
    logic [ROW_W-1:0] visited_mask;
    logic [CNT_W-1:0] emitted_cnt;
    logic [CNT_W-1:0] node_cnt;

    t_out_item sort_out_q [$];
    t_out_item exp_r;

    task automatic push_result(input int node, input logic [STATUS_W-1:0] st, input logic lst);
        t_out_item r;
        r.node_index = node[IDX_W-1:0];
        r.status     = st;
        r.last       = lst;
        sort_out_q.push_back(r);
    endtask

    task automatic run_kahn_sort();
        int n;
        int pick;
        logic [ROW_W-1:0] used;
        logic [ROW_W-1:0] row;
        n = (node_cnt > NODES) ? NODES : int'(node_cnt);
        used = '0;
        for (int j = 0; j < n; j++) used[j] = 1'b1;
        visited_mask = '0;
        emitted_cnt  = '0;
        foreach (in_deg[j]) in_deg[j] = '0;
        for (int i = 0; i < n; i++) begin
            row = adjacency[i] & used;
            for (int j = 0; j < n; j++) begin
                if (row[j]) in_deg[j] = in_deg[j] + 1'b1;
            end
        end
        while (emitted_cnt < n) begin
            pick = -1;
            for (int i = 0; i < n; i++) begin
                if (pick < 0 && !visited_mask[i] && in_deg[i] == '0) pick = i;
            end
            if (pick < 0) begin
                push_result(0, ST_CYCLE, 1'b1);
                return;
            end
            emitted_cnt = emitted_cnt + 1'b1;
            visited_mask[pick] = 1'b1;
            push_result(pick, ST_EMIT, 1'b0);
            row = adjacency[pick] & used;
            for (int j = 0; j < n; j++) begin
                if (row[j] && in_deg[j] != '0) in_deg[j] = in_deg[j] - 1'b1;
            end
        end
        push_result(0, ST_ACYCLIC, 1'b1);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            foreach (adjacency[j]) adjacency[j] = '0;
            foreach (in_deg[j]) in_deg[j] = '0;
            visited_mask = '0;
            emitted_cnt  = '0;
            node_cnt     = NODE_COUNT_RST;
            o_errors     = 0;
            o_results    = 0;
            sort_out_q.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                o_results++;
                if (sort_out_q.size() == 0) begin
                    $error({"result transaction with nothing expected: ",
                            "node_index %0d status %0d last %0d"},
                           i_out_data.node_index, i_out_data.status, i_out_data.last);
                    o_errors++;
                end else begin
                    exp_r = sort_out_q.pop_front();
                    if (i_out_data.node_index !== exp_r.node_index) begin
                        $error("node_index: expected %0d, got %0d",
                               exp_r.node_index, i_out_data.node_index);
                        o_errors++;
                    end
                    if (i_out_data.status !== exp_r.status) begin
                        $error("status: expected %0d, got %0d", exp_r.status, i_out_data.status);
                        o_errors++;
                    end
                    if (i_out_data.last !== exp_r.last) begin
                        $error("last: expected %0d, got %0d", exp_r.last, i_out_data.last);
                        o_errors++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                if (i_in_data.req_type == REQ_START) begin
                    run_kahn_sort();
                end else if (int'(i_in_data.row_index) < NODES) begin
                    adjacency[i_in_data.row_index] = i_in_data.row_bits;
                end
            end
            if (i_cfg_valid && i_cfg_ready) node_cnt = i_cfg_data;
        end
        o_pending = sort_out_q.size();
    end

endmodule

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// stimulus for the topological sort with cycle check: directed graphs for the
// corner cases, then random dags with injected cycles and stray row loads
// under three handshake idle profiles; the checker does the scoring
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import tsc_pkg::*;

    localparam int RAND_ITEMS    = 225;
    localparam int SETTLE_CYCLES = 140;
    localparam int CYCLE_LIMIT   = 400000;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             in_valid  = 1'b0;
    t_in_item         in_data   = '0;
    logic             out_ready = 1'b0;
    logic             cfg_valid = 1'b0;
    logic [CNT_W-1:0] cfg_data  = '0;
    logic             in_ready;
    logic             out_valid;
    t_out_item        out_data;
    logic             cfg_ready;

    int errors;
    int pending;
    int results;
    int cycles       = 0;
    int send_idle    = 20;
    int recv_stall   = 75;
    int items_sent   = 0;
    int sort_runs    = 0;
    int cfg_writes   = 0;
    int cur_nodes    = 32;
    logic [ROW_W-1:0] rows [MAX_NODES_DEF];

    always #4 clk = ~clk;

    always @(negedge clk) out_ready <= ($urandom_range(0, 99) >= recv_stall);

    always @(posedge clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    topological_sort_cycle_check_top i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    tsc_checker u_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_ready  (in_ready),
        .i_in_data   (in_data),
        .i_out_valid (out_valid),
        .i_out_ready (out_ready),
        .i_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .i_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data),
        .o_errors    (errors),
        .o_pending   (pending),
        .o_results   (results)
    );

    task automatic send_item(input logic req, input logic [IDX_W-1:0] idx,
                             input logic [ROW_W-1:0] bits);
        while ($urandom_range(0, 99) < send_idle) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid          <= 1'b1;
        in_data.req_type  <= req;
        in_data.row_index <= idx;
        in_data.row_bits  <= bits;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
        items_sent++;
        if (req == REQ_START) sort_runs++;
    endtask

    task automatic load_row(input int idx, input logic [ROW_W-1:0] bits);
        send_item(REQ_LOAD, idx[IDX_W-1:0], bits);
    endtask

    task automatic start_sort();
        send_item(REQ_START, IDX_W'($urandom_range(0, 31)), $urandom());
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_node_count(input int val);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data  <= val[CNT_W-1:0];
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
        cur_nodes = (val > 32) ? 32 : val;
        cfg_writes++;
    endtask

    // random dag in a shuffled order, some stale or noisy rows, sometimes a back edge
    task automatic load_graph_and_sort();
        int n;
        int perm [MAX_NODES_DEF];
        int tmp;
        int k;
        int p;
        int q;
        logic [ROW_W-1:0] used;
        logic [ROW_W-1:0] row;
        n = cur_nodes;
        used = '0;
        for (int i = 0; i < n; i++) begin
            used[i] = 1'b1;
            perm[i] = i;
        end
        for (int i = n - 1; i > 0; i--) begin
            k = $urandom_range(0, i);
            tmp = perm[i];
            perm[i] = perm[k];
            perm[k] = tmp;
        end
        for (int i = 0; i < n; i++) begin
            row = '0;
            for (int j = i + 1; j < n; j++) begin
                if ($urandom_range(0, 3) == 0) row[perm[j]] = 1'b1;
            end
            if ($urandom_range(0, 3) == 0) row = row | ($urandom() & ~used);
            if ($urandom_range(0, 19) == 0) row = $urandom();
            if ($urandom_range(0, 9) != 0) begin
                rows[perm[i]] = row;
                load_row(perm[i], row);
            end
        end
        if (n > 0 && $urandom_range(0, 5) == 0) begin
            p = $urandom_range(0, n - 1);
            q = $urandom_range(0, p);
            row = rows[perm[p]] | (32'd1 << perm[q]);
            rows[perm[p]] = row;
            load_row(perm[p], row);
        end
        if ($urandom_range(0, 9) == 0) load_row($urandom_range(0, 31), $urandom());
        start_sort();
    endtask

    function automatic int pick_node_count();
        int r;
        r = $urandom_range(0, 19);
        case (r)
            0: return 0;
            1: return 32;
            2: return $urandom_range(33, 63);
            3: return $urandom_range(9, 31);
            default: return $urandom_range(1, 8);
        endcase
    endfunction

    initial begin
        int rand_start;
        foreach (rows[j]) rows[j] = '0;
        @(posedge clk);
        @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // empty graph at reset count: all nodes in order
        start_sort();
        write_node_count(4);
        load_row(0, 32'hFFFF_FFF6);
        load_row(1, 32'h0000_0008);
        load_row(2, 32'h0000_0008);
        load_row(3, 32'h0000_0000);
        start_sort();
        load_row(3, 32'h0000_0001);
        start_sort();
        load_row(3, 32'h0000_0008);
        start_sort();
        load_row(31, 32'hFFFF_FFFF);
        start_sort();
        write_node_count(0);
        start_sort();
        write_node_count(63);
        start_sort();
        write_node_count(1);
        start_sort();
        load_row(0, 32'h0000_0001);
        start_sort();
        write_node_count(32);
        load_row(31, 32'h0000_0000);
        load_row(3, 32'h0000_0000);
        load_row(0, 32'h0000_0006);
        start_sort();
        rows[0] = 32'h0000_0006;
        rows[1] = 32'h0000_0008;
        rows[2] = 32'h0000_0008;

        rand_start = items_sent;
        for (int mode = 0; mode < 3; mode++) begin
            case (mode)
                0: begin
                    send_idle  = 20;
                    recv_stall = 75;
                end
                1: begin
                    send_idle  = 75;
                    recv_stall = 20;
                end
                default: begin
                    send_idle  = 0;
                    recv_stall = 0;
                end
            endcase
            while (items_sent - rand_start < (mode + 1) * RAND_ITEMS / 3) begin
                if ($urandom_range(0, 1) == 0) write_node_count(pick_node_count());
                load_graph_and_sort();
            end
        end

        wait_idle();
        $display("sent %0d input transactions (%0d sort runs) with %0d node count writes",
                 items_sent, sort_runs, cfg_writes);
        $display("checked %0d result transactions over three idle profiles", results);
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/tsc_pkg.sv
rtl/tsc_ram.sv
rtl/tsc_lane.sv
rtl/tsc_merge.sv
rtl/topological_sort_cycle_check_top.sv
tb/tsc_checker.sv
tb/tb.sv
